[sv/surjection_count_mod_prime_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the surjection counter
// Immediate-style wrappers around concurrent properties on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef SURJECTION_COUNT_MOD_PRIME_ASSERT_SVH
`define SURJECTION_COUNT_MOD_PRIME_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SCMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/scmp_pkg.sv]
// ---------------------------------------------------------------------------
// scmp_pkg
// Shared constants and types for the surjection counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scmp_pkg;

  localparam logic [29:0] PRIME_MOD  = 30'd1000000007;
  // floor(2^60 / PRIME_MOD), Barrett reciprocal
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  typedef struct packed {
    logic valid;
    logic last;
  } mm_tag_t;

endpackage

`default_nettype wire

[sv/scmp_mulmod.sv]
// ---------------------------------------------------------------------------
// scmp_mulmod
// Five-stage pipelined a*b mod prime, Barrett reduction, tag rides along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scmp_mulmod
  import scmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [29:0] a_i,
  input  wire logic [29:0] b_i,
  input  wire mm_tag_t     tag_i,
  output logic      [29:0] r_o,
  output mm_tag_t          tag_o
);

  logic [59:0] prod_r;
  logic [61:0] q1_r;
  logic [31:0] x1_r, x2_r, qp_r, r1_r;
  logic [29:0] r2_r;
  mm_tag_t     t1_r, t2_r, t3_r, t4_r, t5_r;

  logic [59:0] prod_nxt;
  logic [61:0] q1_nxt;
  logic [31:0] qp_nxt, diff, r1_nxt;
  logic [29:0] r2_nxt;

  assign prod_nxt = {30'd0, a_i} * {30'd0, b_i};
  assign q1_nxt   = {31'd0, prod_r[59:29]} * {31'd0, BARRETT_MU};
  // only the low word matters: remainder stays below 3p < 2^32
  assign qp_nxt   = {1'b0, q1_r[61:31]} * {2'b00, PRIME_MOD};
  assign diff     = x2_r - qp_r;
  assign r1_nxt   = (diff >= {2'b00, PRIME_MOD}) ? diff - {2'b00, PRIME_MOD} : diff;
  assign r2_nxt   = (r1_r >= {2'b00, PRIME_MOD}) ? 30'(r1_r - {2'b00, PRIME_MOD})
                                                 : r1_r[29:0];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q1_r   <= q1_nxt;
    x1_r   <= prod_r[31:0];
    qp_r   <= qp_nxt;
    x2_r   <= x1_r;
    r1_r   <= r1_nxt;
    r2_r   <= r2_nxt;
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
      t5_r <= '0;
    end else begin
      t1_r <= tag_i;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
    end
  end

  assign r_o   = r2_r;
  assign tag_o = t5_r;

endmodule

`default_nettype wire

[sv/surjection_count_mod_prime.sv]
// Throughput: one query at a time; the single multiply/Barrett pipeline fed from the
//   binomial and row memories takes one term per cycle, drained at each column end.
// Reset: synchronous active-low; afterwards the binomial table is built by Pascal's rule
//   with in_tready low.
// ---------------------------------------------------------------------------
// surjection_count_mod_prime
// Counts onto strings of length N over M symbols modulo 1000000007 by a row
// dynamic program kept in block memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module surjection_count_mod_prime
  import scmp_pkg::*;
#(
  parameter int MAX_LEN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] symbol_count, [15:8] string_length
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // [29:0] count_mod, [31:30] zero
);

  `include "surjection_count_mod_prime_assert.svh"

  localparam int JW       = $clog2(MAX_LEN + 1);
  localparam int DP_DEPTH = 2 ** (JW + 1);
  localparam int BN_DEPTH = 2 ** (2 * JW);
  localparam logic [7:0]    MAX8 = 8'(MAX_LEN);
  localparam logic [JW-1:0] MAXJ = JW'(MAX_LEN);
  localparam logic [JW-1:0] ONEJ = JW'(1);
  localparam logic [JW-1:0] TWOJ = JW'(2);

  // controller states
  localparam logic [2:0] S_INIT  = 3'd0;  // Pascal row build, one read per cycle
  localparam logic [2:0] S_IGAP  = 3'd1;  // bubble so the row's last write lands
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;  // stream terms of one column into the MAC
  localparam logic [2:0] S_DRAIN = 3'd4;  // wait for the column sum
  localparam logic [2:0] S_DONE  = 3'd5;  // park result until output stage is free

  // memories: binomial table addressed {row, col}; two DP rows addressed {row, j}
  logic [29:0] bin_mem [BN_DEPTH];
  logic [29:0] dp_mem  [DP_DEPTH];

  logic [2:0]    state_r;
  logic [JW-1:0] bj_r, bk_r, bj_d_r, bk_d_r;
  logic          binit_v_r;
  logic [29:0]   blast_r;

  logic [JW-1:0] m_r, n_r, i_r, j_r, k_r;
  logic          pb_r;        // which DP row holds the previous symbol count
  logic [29:0]   acc_r, res_r;
  logic          out_tvalid_r;
  logic [29:0]   out_data_r;

  logic [29:0]   dp_rd_r, bin_rd_r;
  mm_tag_t       rd_tag_r;

  logic [2*JW-1:0] bin_raddr, bin_waddr;
  logic [JW:0]     dp_raddr, dp_waddr;
  logic            bin_we, dp_we;
  logic [29:0]     bin_wdata;
  logic [29:0]     pas_cur, pas_prv;
  logic [30:0]     pas_sum;

  logic [29:0]   mm_r;
  mm_tag_t       mm_tag;
  mm_tag_t       issue_tag;
  logic [30:0]   acc_sum;
  logic [29:0]   acc_nxt;
  logic          col_done;

  logic [7:0]    m8, n8;
  logic          zero_case;

  assign m8 = in_tdata[7:0];
  assign n8 = in_tdata[15:8];
  assign zero_case = (m8 == 8'd0) || (n8 == 8'd0) || (m8 > MAX8) || (n8 > MAX8) || (m8 > n8);

  assign in_tready = (state_r == S_IDLE);

  // ---- Pascal build: C[j][k] = C[j-1][k-1] + C[j-1][k], edges masked to zero
  assign pas_cur   = (bk_d_r == bj_d_r) ? 30'd0 : bin_rd_r;
  assign pas_prv   = (bk_d_r == '0)     ? 30'd0 : blast_r;
  assign pas_sum   = {1'b0, pas_cur} + {1'b0, pas_prv};
  assign bin_we    = binit_v_r;
  assign bin_waddr = {bj_d_r, bk_d_r};
  assign bin_wdata = (bj_d_r == '0) ? 30'd1 :
                     (pas_sum >= {1'b0, PRIME_MOD}) ? 30'(pas_sum - {1'b0, PRIME_MOD})
                                                    : pas_sum[29:0];

  // ---- read addresses
  assign bin_raddr = (state_r == S_INIT) ? {bj_r - ONEJ, bk_r} : {j_r, k_r};
  assign dp_raddr  = {pb_r, j_r - k_r};

  assign issue_tag.valid = (state_r == S_ISSUE);
  assign issue_tag.last  = (k_r == j_r - i_r + ONEJ);

  always_ff @(posedge clk) begin
    dp_rd_r  <= dp_mem[dp_raddr];
    bin_rd_r <= bin_mem[bin_raddr];
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    if (dp_we) begin
      dp_mem[dp_waddr] <= acc_nxt;
    end
  end

  // ---- shared multiply / reduce; row 1 is all ones so skip its memory
  scmp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .a_i   ((i_r == TWOJ) ? 30'd1 : dp_rd_r),
    .b_i   (bin_rd_r),
    .tag_i (rd_tag_r),
    .r_o   (mm_r),
    .tag_o (mm_tag)
  );

  assign acc_sum  = {1'b0, acc_r} + {1'b0, mm_r};
  assign acc_nxt  = (acc_sum >= {1'b0, PRIME_MOD}) ? 30'(acc_sum - {1'b0, PRIME_MOD})
                                                   : acc_sum[29:0];
  assign col_done = mm_tag.valid && mm_tag.last;
  assign dp_we    = col_done;
  assign dp_waddr = {~pb_r, j_r};

  always_ff @(posedge clk) begin
    if (binit_v_r) begin
      blast_r <= bin_rd_r;
    end
    bj_d_r <= bj_r;
    bk_d_r <= bk_r;
    if (!rst_n) begin
      state_r      <= S_INIT;
      bj_r         <= '0;
      bk_r         <= '0;
      binit_v_r    <= 1'b0;
      rd_tag_r     <= '0;
      acc_r        <= '0;
      out_tvalid_r <= 1'b0;
      pb_r         <= 1'b0;
      m_r          <= '0;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
    end else begin
      binit_v_r <= (state_r == S_INIT);
      rd_tag_r  <= issue_tag;
      // output stage: load from DONE when free, else clear on handshake
      if ((state_r == S_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (mm_tag.valid) begin
        acc_r <= col_done ? 30'd0 : acc_nxt;
      end

      case (state_r)
        S_INIT: begin
          if (bk_r == bj_r) begin
            bk_r    <= '0;
            state_r <= S_IGAP;
          end else begin
            bk_r <= bk_r + ONEJ;
          end
        end
        S_IGAP: begin
          if (bj_r == MAXJ) begin
            state_r <= S_IDLE;
          end else begin
            bj_r    <= bj_r + ONEJ;
            state_r <= S_INIT;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            m_r <= m8[JW-1:0];
            n_r <= n8[JW-1:0];
            i_r <= TWOJ;
            j_r <= TWOJ;
            k_r <= ONEJ;
            if (zero_case) begin
              res_r   <= 30'd0;
              state_r <= S_DONE;
            end else if (m8 == 8'd1) begin
              res_r   <= 30'd1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          k_r <= k_r + ONEJ;
          if (issue_tag.last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (col_done) begin
            k_r <= ONEJ;
            if (j_r == n_r) begin
              if (i_r == m_r) begin
                res_r   <= acc_nxt;
                state_r <= S_DONE;
              end else begin
                i_r     <= i_r + ONEJ;
                j_r     <= i_r + ONEJ;
                pb_r    <= ~pb_r;
                state_r <= S_ISSUE;
              end
            end else begin
              j_r     <= j_r + ONEJ;
              state_r <= S_ISSUE;
            end
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_data_r};

  // ---- checks
  `SCMP_ASSERT_SAME(a_out_reduced, out_tvalid, out_tdata < {2'b00, PRIME_MOD},
    "result not reduced modulo prime")
  `SCMP_ASSERT_SAME(a_idle_empty, in_tready, !mm_tag.valid && !rd_tag_r.valid,
    "input accepted while MAC pipeline busy")
  `SCMP_ASSERT_SAME(a_last_in_drain, col_done, state_r == S_DRAIN,
    "column sum arrived outside drain")

endmodule

`default_nettype wire
